FILE: rtl/region_edge_select_reindex_macros.svh
// Assertion macros shared by the checker of region_edge_select_reindex.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef REGION_EDGE_SELECT_REINDEX_MACROS_SVH
`define REGION_EDGE_SELECT_REINDEX_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define RESR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define RESR_ASSERT_IMPL(lbl, ante, cons, msg) \
  `RESR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/resr_pkg.sv
// Package of region_edge_select_reindex: sizes, payload types, register codes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps

package resr_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COORD_WIDTH = 24;
  localparam int INDEX_WIDTH = 20;

  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int COUNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int EDGE_W   = 20;
  localparam int RAD_W    = COORD_WIDTH - 1;
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int SQ_W     = 2 * RAD_W;
  localparam int ACC_W    = SQ_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_WIDTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_X = 3'd0,
    CFG_CENTRE_Y = 3'd1,
    CFG_CENTRE_Z = 3'd2,
    CFG_RADIUS   = 3'd3,
    CFG_USE_CUBE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] first_vertex;
    logic [COORD_WIDTH-1:0] first_x;
    logic [COORD_WIDTH-1:0] first_y;
    logic [COORD_WIDTH-1:0] first_z;
    logic [INDEX_WIDTH-1:0] second_vertex;
    logic [COORD_WIDTH-1:0] second_x;
    logic [COORD_WIDTH-1:0] second_y;
    logic [COORD_WIDTH-1:0] second_z;
    logic                   last_edge;
  } in_item_t;

  typedef struct packed {
    logic               edge_selected;
    logic [ADDR_W-1:0]  new_first_index;
    logic [ADDR_W-1:0]  new_second_index;
    logic               table_overflow;
    logic [EDGE_W-1:0]  selected_edges;
    logic [COUNT_W-1:0] distinct_vertices;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSQ,
    S_DIFF,
    S_SQUARE,
    S_ACCUM,
    S_DECIDE,
    S_LK_START,
    S_LK_SCAN,
    S_LK_ADD,
    S_FINISH
  } resr_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_item;
    logic       load_rsq;
    logic       diff;
    logic       square;
    logic       accum;
    logic       decide;
    logic       scan_start;
    logic       scan_step;
    logic       take_hit;
    logic       add;
    logic       finish;
    logic       pt;
    logic [1:0] axis;
    logic       end_sel;
  } resr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sel_next;
    logic hit;
    logic scan_last;
    logic count_zero;
  } resr_stat_t;

endpackage

FILE: rtl/resr_if.sv
// Valid/ready channel interfaces of region_edge_select_reindex.
// Depends on resr_pkg for the payload types.
`timescale 1ns / 1ps

interface resr_in_if;
  import resr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface resr_out_if;
  import resr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/resr_datapath.sv
// Datapath: config registers, region test with one shared multiplier,
// vertex table memory with scan pointer, counters and result register.
// Depends on resr_pkg.
`timescale 1ns / 1ps

module resr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [resr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [resr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  resr_pkg::in_item_t                 in_data,
  input  resr_pkg::resr_cmd_t                cmd,
  output resr_pkg::resr_stat_t               stat,
  output resr_pkg::out_item_t                out_data
);
  import resr_pkg::*;

  logic [COORD_WIDTH-1:0] centre_x_r, centre_y_r, centre_z_r;
  logic [RAD_W-1:0]       radius_r;
  logic                   use_cube_r;

  in_item_t               item_r;
  logic [DIFF_W-1:0]      absd_r;
  logic                   far_r;
  logic [SQ_W-1:0]        sq_r;
  logic [SQ_W-1:0]        rsq_r;
  logic [ACC_W-1:0]       acc_r;
  logic                   sel_r;
  logic                   ovf_r;
  logic [ADDR_W-1:0]      idx1_r, idx2_r;
  logic [ADDR_W-1:0]      scan_idx_r;
  logic [COUNT_W-1:0]     vcount_r;
  logic [EDGE_W-1:0]      ecount_r;
  out_item_t              out_r;

  logic [INDEX_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [INDEX_WIDTH-1:0] rd_data_r;

  logic [COORD_WIDTH-1:0] c_sel, p_sel;
  logic [DIFF_W-1:0]      diff, absd;
  logic                   far_now;
  logic [RAD_W-1:0]       mul_a;
  logic [SQ_W-1:0]        prod;
  logic                   pt_in_region;
  logic [INDEX_WIDTH-1:0] target;
  logic                   full;
  logic [ADDR_W-1:0]      rd_addr;
  logic [EDGE_W-1:0]      ecount_inc;

  // Configuration writes; unknown indexes fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      centre_z_r <= '0;
      radius_r   <= '0;
      use_cube_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTRE_X: centre_x_r <= cfg_data[COORD_WIDTH-1:0];
        CFG_CENTRE_Y: centre_y_r <= cfg_data[COORD_WIDTH-1:0];
        CFG_CENTRE_Z: centre_z_r <= cfg_data[COORD_WIDTH-1:0];
        CFG_RADIUS:   radius_r   <= cfg_data[RAD_W-1:0];
        CFG_USE_CUBE: use_cube_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.axis)
      2'd0: begin
        c_sel = centre_x_r;
        p_sel = cmd.pt ? item_r.second_x : item_r.first_x;
      end
      2'd1: begin
        c_sel = centre_y_r;
        p_sel = cmd.pt ? item_r.second_y : item_r.first_y;
      end
      default: begin
        c_sel = centre_z_r;
        p_sel = cmd.pt ? item_r.second_z : item_r.first_z;
      end
    endcase
  end

  assign diff    = {c_sel[COORD_WIDTH-1], c_sel} - {p_sel[COORD_WIDTH-1], p_sel};
  assign absd    = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign far_now = absd > {2'b00, radius_r};

  // One multiplier serves radius squared and the per-axis squares.
  assign mul_a = cmd.load_rsq ? radius_r : absd_r[RAD_W-1:0];
  assign prod  = SQ_W'(mul_a) * SQ_W'(mul_a);

  assign pt_in_region = !far_r && (use_cube_r || (acc_r <= ACC_W'(rsq_r)));

  assign target  = cmd.end_sel ? item_r.second_vertex : item_r.first_vertex;
  assign full    = vcount_r == COUNT_W'(TABLE_DEPTH);
  assign rd_addr = cmd.scan_start ? '0 : scan_idx_r + 1'b1;

  assign ecount_inc = (sel_r && (ecount_r != {EDGE_W{1'b1}})) ? ecount_r + 1'b1 : ecount_r;

  assign stat.sel_next   = sel_r | pt_in_region;
  assign stat.hit        = rd_data_r == target;
  assign stat.scan_last  = (COUNT_W'(scan_idx_r) + COUNT_W'(1)) == vcount_r;
  assign stat.count_zero = vcount_r == '0;

  // Per-item payload, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
      sel_r  <= 1'b0;
      ovf_r  <= 1'b0;
      idx1_r <= '0;
      idx2_r <= '0;
      acc_r  <= '0;
      far_r  <= 1'b0;
    end
    if (cmd.load_rsq) rsq_r <= prod;
    if (cmd.diff) begin
      absd_r <= absd;
      far_r  <= far_r | far_now;
    end
    if (cmd.square) sq_r <= prod;
    if (cmd.accum) acc_r <= acc_r + ACC_W'(sq_r);
    if (cmd.decide) begin
      sel_r <= sel_r | pt_in_region;
      acc_r <= '0;
      far_r <= 1'b0;
    end
    if (cmd.scan_start) scan_idx_r <= '0;
    if (cmd.scan_step)  scan_idx_r <= scan_idx_r + 1'b1;
    if (cmd.take_hit) begin
      if (cmd.end_sel) idx2_r <= scan_idx_r;
      else             idx1_r <= scan_idx_r;
    end
    if (cmd.add) begin
      if (full) begin
        ovf_r <= 1'b1;
        if (cmd.end_sel) idx2_r <= ADDR_W'(TABLE_DEPTH - 1);
        else             idx1_r <= ADDR_W'(TABLE_DEPTH - 1);
      end else begin
        if (cmd.end_sel) idx2_r <= vcount_r[ADDR_W-1:0];
        else             idx1_r <= vcount_r[ADDR_W-1:0];
      end
    end
    if (cmd.finish) begin
      out_r.edge_selected     <= sel_r;
      out_r.new_first_index   <= idx1_r;
      out_r.new_second_index  <= idx2_r;
      out_r.table_overflow    <= ovf_r;
      out_r.selected_edges    <= ecount_inc;
      out_r.distinct_vertices <= vcount_r;
    end
  end

  // Query counters: append grows the table, last edge clears both.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      ecount_r <= '0;
    end else begin
      if (cmd.add && !full) vcount_r <= vcount_r + 1'b1;
      if (cmd.finish) begin
        ecount_r <= item_r.last_edge ? '0 : ecount_inc;
        if (item_r.last_edge) vcount_r <= '0;
      end
    end
  end

  // Vertex table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.add && !full) mem[vcount_r[ADDR_W-1:0]] <= target;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign out_data = out_r;

endmodule

FILE: rtl/resr_ctrl.sv
// Controller state machine: sequences region test and the two table lookups,
// owns the input ready and result valid. Depends on resr_pkg.
`timescale 1ns / 1ps

module resr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  resr_pkg::resr_stat_t  stat,
  output resr_pkg::resr_cmd_t   cmd
);
  import resr_pkg::*;

  resr_state_t state_r, state_nxt;
  logic [1:0]  axis_r;
  logic        pt_r;
  logic        end_r;
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;

  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_RSQ;
      S_RSQ:      state_nxt = S_DIFF;
      S_DIFF:     state_nxt = S_SQUARE;
      S_SQUARE:   state_nxt = S_ACCUM;
      S_ACCUM:    state_nxt = (axis_r == 2'd2) ? S_DECIDE : S_DIFF;
      S_DECIDE: begin
        if (!pt_r)              state_nxt = S_DIFF;
        else if (stat.sel_next) state_nxt = S_LK_START;
        else                    state_nxt = S_FINISH;
      end
      S_LK_START: state_nxt = stat.count_zero ? S_LK_ADD : S_LK_SCAN;
      S_LK_SCAN: begin
        if (stat.hit)            state_nxt = end_r ? S_FINISH : S_LK_START;
        else if (stat.scan_last) state_nxt = S_LK_ADD;
      end
      S_LK_ADD:   state_nxt = end_r ? S_FINISH : S_LK_START;
      S_FINISH:   if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd            = '0;
    cmd.pt         = pt_r;
    cmd.axis       = axis_r;
    cmd.end_sel    = end_r;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_RSQ:      cmd.load_rsq   = 1'b1;
      S_DIFF:     cmd.diff       = 1'b1;
      S_SQUARE:   cmd.square     = 1'b1;
      S_ACCUM:    cmd.accum      = 1'b1;
      S_DECIDE:   cmd.decide     = 1'b1;
      S_LK_START: cmd.scan_start = !stat.count_zero;
      S_LK_SCAN: begin
        cmd.take_hit  = stat.hit;
        cmd.scan_step = !stat.hit && !stat.scan_last;
      end
      S_LK_ADD:   cmd.add        = 1'b1;
      S_FINISH:   cmd.finish     = out_load;
      default: ;
    endcase
  end

  always_comb begin
    if (out_load)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 2'd0;
      pt_r        <= 1'b0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_IDLE) begin
        axis_r <= 2'd0;
        pt_r   <= 1'b0;
        end_r  <= 1'b0;
      end
      if (state_r == S_ACCUM) axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
      if (state_r == S_DECIDE) pt_r <= 1'b1;
      if ((state_r == S_LK_ADD) || ((state_r == S_LK_SCAN) && stat.hit)) end_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/region_edge_select_reindex.sv
// Top level of region_edge_select_reindex: joins controller and datapath.
// Depends on resr_pkg, resr_if, resr_ctrl and resr_datapath.
`timescale 1ns / 1ps

// Usage
// - in_ch carries one graph edge per transfer: two vertex indices, their
//   coordinates and the last_edge marker. out_ch returns exactly one result
//   per edge, in order.
// - cfg_we/cfg_index/cfg_data write centre, radius and test shape; write
//   them only while no edge is in flight.
// - One edge at a time. The region test computes radius squared, then a
//   difference, square and accumulate step per axis plus a decision per
//   end, on one shared multiplier. A selected edge then scans the vertex
//   table once per end through the single read port, one entry a cycle,
//   and appends the vertex if absent; an edge outside the region skips the
//   lookups. The next edge is taken in the idle state that follows the
//   result load.
// - Results sit in an output register; the next edge is taken while a
//   result waits. If out_ch stalls, the following result waits with the
//   controller in its finish state until the register frees up.
// - Reset clears configuration, counts and valid flags; table contents are
//   not cleared, only entries below the fill count are ever compared.
module region_edge_select_reindex (
  input  logic                             clk,
  input  logic                             rst_n,
  resr_in_if.sink                          in_ch,
  resr_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [resr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [resr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import resr_pkg::*;

  resr_cmd_t  cmd;
  resr_stat_t stat;

  resr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  resr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_ch.data)
  );

endmodule

FILE: rtl/resr_checker.sv
// Port-level checker for region_edge_select_reindex and its bind.
// Depends on resr_pkg and region_edge_select_reindex_macros.svh.
`timescale 1ns / 1ps
`include "region_edge_select_reindex_macros.svh"

module resr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             edge_selected,
  input logic [resr_pkg::ADDR_W-1:0]      new_first_index,
  input logic [resr_pkg::ADDR_W-1:0]      new_second_index,
  input logic                             table_overflow,
  input logic [resr_pkg::EDGE_W-1:0]      selected_edges,
  input logic [resr_pkg::COUNT_W-1:0]     distinct_vertices
);
  import resr_pkg::*;

  `RESR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `RESR_ASSERT_IMPL(a_unsel_zero, out_valid && !edge_selected, new_first_index == '0 && new_second_index == '0 && !table_overflow, "unselected edge with nonzero index")
  `RESR_ASSERT_IMPL(a_count_range, out_valid, distinct_vertices <= COUNT_W'(TABLE_DEPTH), "vertex count beyond table depth")
  `RESR_ASSERT_IMPL(a_ovf_full, out_valid && table_overflow, distinct_vertices == COUNT_W'(TABLE_DEPTH) && edge_selected, "overflow without full table")
  `RESR_ASSERT_IMPL(a_sel_count, out_valid && edge_selected, selected_edges != '0 && distinct_vertices != '0, "selected edge not counted")

endmodule

bind region_edge_select_reindex resr_checker u_resr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .edge_selected     (out_ch.data.edge_selected),
  .new_first_index   (out_ch.data.new_first_index),
  .new_second_index  (out_ch.data.new_second_index),
  .table_overflow    (out_ch.data.table_overflow),
  .selected_edges    (out_ch.data.selected_edges),
  .distinct_vertices (out_ch.data.distinct_vertices)
);

FILE: dv/region_edge_select_reindex_tb.sv
// Self-checking testbench for region_edge_select_reindex: drives edges over
// the valid/ready input channel, predicts every result and checks it field by field.
// Depends on resr_pkg, resr_if and the region_edge_select_reindex RTL.
`timescale 1ns / 1ps

module region_edge_select_reindex_tb;
  import resr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int ITEM_TARGET  = 1100;
  localparam int MAX_WAIT     = 11;
  // The limit allows many times the worst single edge with a full table and
  // many times the long receiver hold-off before giving up.
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_OFF     = 1500;
  localparam int TAIL_CYCLES  = 600;
  localparam int FILL_LINKS   = 170;
  localparam int PRESSURE_PHASE = 2;
  localparam int PAUSE_PHASE    = 5;
  localparam int MAX_PRINTS     = 40;

  localparam int CMIN = -(2 ** (COORD_WIDTH - 1));
  localparam int CMAX = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int RMAX = 2 ** RAD_W - 1;
  localparam int EDGE_MAX = 2 ** EDGE_W - 1;
  localparam int FIRST_UNUSED_REG = CFG_USE_CUBE + 1;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] centre_x;
    logic [COORD_WIDTH-1:0] centre_y;
    logic [COORD_WIDTH-1:0] centre_z;
    logic [RAD_W-1:0]       radius;
    logic                   use_cube;
  } region_cfg_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
  } coord3_t;

  typedef enum int { PT_CENTRE, PT_NEAR, PT_RIM, PT_ANY } point_kind_t;

  typedef struct {
    bit          reconf;
    region_cfg_t region;
    in_item_t    stim;
    bit          typed;
    out_item_t   want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  resr_in_if  in_ch();
  resr_out_if out_ch();

  region_edge_select_reindex dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow of the block: region registers, vertex slots and query counts.
  logic signed [COORD_WIDTH-1:0] region_cx, region_cy, region_cz;
  logic [RAD_W-1:0]              region_rad;
  logic                          region_cube;
  logic [INDEX_WIDTH-1:0]        vertex_slots [TABLE_DEPTH];
  int                            slots_used;
  int                            query_edges;

  // Results still owed by the block, oldest first.
  out_item_t reindex_due [$];
  probe_row_t probe_rows [$];

  int  mismatches;
  int  results_checked;
  int  sent_links;
  int  selected_links;
  int  full_hits;
  int  region_loads;
  int  quiet_cycles;
  int  hold_off_len;
  bit  steady_in;
  bit  steady_out;
  out_item_t due_head;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned abs_gap(logic signed [COORD_WIDTH-1:0] a,
                                              logic signed [COORD_WIDTH-1:0] b);
    longint sa, sb;
    sa = a;
    sb = b;
    return (sa >= sb) ? sa - sb : sb - sa;
  endfunction

  // Any axis beyond the radius is out for both shapes; this also keeps the
  // sum of squares inside 64 bits for the sphere test.
  function automatic bit in_region(logic signed [COORD_WIDTH-1:0] px,
                                   logic signed [COORD_WIDTH-1:0] py,
                                   logic signed [COORD_WIDTH-1:0] pz);
    longint unsigned dx, dy, dz, r;
    dx = abs_gap(region_cx, px);
    dy = abs_gap(region_cy, py);
    dz = abs_gap(region_cz, pz);
    r  = region_rad;
    if (dx > r || dy > r || dz > r) return 1'b0;
    if (region_cube) return 1'b1;
    return (dx * dx + dy * dy + dz * dz) <= r * r;
  endfunction

  // Find the vertex among the used slots, append it if absent; a full table
  // flags overflow and saturates the index.
  function automatic logic [ADDR_W-1:0] claim_slot(logic [INDEX_WIDTH-1:0] v,
                                                   inout bit ovf);
    for (int i = 0; i < slots_used; i++)
      if (vertex_slots[i] == v) return ADDR_W'(i);
    if (slots_used >= TABLE_DEPTH) begin
      ovf = 1'b1;
      return ADDR_W'(TABLE_DEPTH - 1);
    end
    vertex_slots[slots_used] = v;
    slots_used++;
    return ADDR_W'(slots_used - 1);
  endfunction

  function automatic out_item_t reindex_edge(in_item_t s);
    out_item_t r;
    bit        sel;
    bit        ovf;
    r   = '0;
    ovf = 1'b0;
    sel = in_region(s.first_x, s.first_y, s.first_z) ||
          in_region(s.second_x, s.second_y, s.second_z);
    if (sel) begin
      r.new_first_index  = claim_slot(s.first_vertex, ovf);
      r.new_second_index = claim_slot(s.second_vertex, ovf);
      if (query_edges < EDGE_MAX) query_edges++;
    end
    r.edge_selected     = sel;
    r.table_overflow    = ovf;
    r.selected_edges    = EDGE_W'(query_edges);
    r.distinct_vertices = COUNT_W'(slots_used);
    // The last edge closes the query: both counts start over.
    if (s.last_edge) begin
      slots_used  = 0;
      query_edges = 0;
    end
    return r;
  endfunction

  function automatic void write_region_reg(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_CENTRE_X: region_cx   = d;
      CFG_CENTRE_Y: region_cy   = d;
      CFG_CENTRE_Z: region_cz   = d;
      CFG_RADIUS:   region_rad  = d[RAD_W-1:0];
      CFG_USE_CUBE: region_cube = d[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_link(int v1, int x1, int y1, int z1,
                                       int v2, int x2, int y2, int z2, bit last);
    in_item_t s;
    s.first_vertex  = INDEX_WIDTH'(v1);
    s.first_x       = COORD_WIDTH'(x1);
    s.first_y       = COORD_WIDTH'(y1);
    s.first_z       = COORD_WIDTH'(z1);
    s.second_vertex = INDEX_WIDTH'(v2);
    s.second_x      = COORD_WIDTH'(x2);
    s.second_y      = COORD_WIDTH'(y2);
    s.second_z      = COORD_WIDTH'(z2);
    s.last_edge     = last;
    return s;
  endfunction

  function automatic out_item_t mk_result(bit sel, int i1, int i2, bit ovf,
                                          int edges, int verts);
    out_item_t r;
    r.edge_selected     = sel;
    r.new_first_index   = ADDR_W'(i1);
    r.new_second_index  = ADDR_W'(i2);
    r.table_overflow    = ovf;
    r.selected_edges    = EDGE_W'(edges);
    r.distinct_vertices = COUNT_W'(verts);
    return r;
  endfunction

  function automatic region_cfg_t mk_region(int cx, int cy, int cz, int rad, bit cube);
    region_cfg_t rg;
    rg.centre_x = COORD_WIDTH'(cx);
    rg.centre_y = COORD_WIDTH'(cy);
    rg.centre_z = COORD_WIDTH'(cz);
    rg.radius   = RAD_W'(rad);
    rg.use_cube = cube;
    return rg;
  endfunction

  // Early phases pin the extremes; later ones mix radius scales at random.
  function automatic region_cfg_t pick_region(int phase);
    region_cfg_t rg;
    rg.centre_x = COORD_WIDTH'($urandom);
    rg.centre_y = COORD_WIDTH'($urandom);
    rg.centre_z = COORD_WIDTH'($urandom);
    rg.use_cube = 1'($urandom);
    case ($urandom_range(0, 3))
      0:       rg.radius = RAD_W'($urandom_range(0, 255));
      1:       rg.radius = RAD_W'($urandom_range(0, 65535));
      2:       rg.radius = RAD_W'($urandom);
      default: rg.radius = $urandom_range(0, 1) ? RAD_W'(RMAX) : '0;
    endcase
    case (phase)
      0: rg = mk_region(CMIN, CMIN, CMIN, RMAX, 1'b0);
      1: rg = mk_region(CMAX, CMAX, CMAX, RMAX, 1'b1);
      2: rg.radius = '0;
      default: ;
    endcase
    return rg;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] to_coord(longint v);
    if (v > CMAX) v = CMAX;
    else if (v < CMIN) v = CMIN;
    return v[COORD_WIDTH-1:0];
  endfunction

  // Place a point relative to the current centre: on it, inside the
  // bounding cube, on or just past the rim, or anywhere at all.
  function automatic coord3_t pick_point(point_kind_t kind);
    longint base [3];
    longint c [3];
    longint r;
    r = region_rad;
    base[0] = region_cx;
    base[1] = region_cy;
    base[2] = region_cz;
    for (int a = 0; a < 3; a++) begin
      case (kind)
        PT_CENTRE: c[a] = base[a];
        PT_NEAR:   c[a] = base[a] + longint'($urandom_range(0, 2 * r)) - r;
        PT_RIM: begin
          case ($urandom_range(0, 4))
            0:       c[a] = base[a] - r - 1;
            1:       c[a] = base[a] - r;
            2:       c[a] = base[a];
            3:       c[a] = base[a] + r;
            default: c[a] = base[a] + r + 1;
          endcase
        end
        default:   c[a] = longint'($signed(COORD_WIDTH'($urandom)));
      endcase
    end
    return '{to_coord(c[0]), to_coord(c[1]), to_coord(c[2])};
  endfunction

  function automatic point_kind_t draw_kind();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return PT_CENTRE;
    if (roll < 6)  return PT_NEAR;
    if (roll < 8)  return PT_RIM;
    return PT_ANY;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Offer one edge and hold it until the transfer. Valid stays high when no
  // gap is drawn, so back-to-back edges never drop it within one step.
  task automatic send_edge(input in_item_t s, input bit typed, input out_item_t want);
    int        gap;
    out_item_t guess;
    gap = steady_in ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    do @(posedge clk); while (!in_ch.ready);
    guess = reindex_edge(s);
    reindex_due.push_back(typed ? want : guess);
    sent_links++;
    if (guess.edge_selected) selected_links++;
    if (guess.table_overflow) full_hits++;
  endtask

  // Drop valid and wait until every owed result has been checked.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (reindex_due.size() != 0);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    write_region_reg(idx, d);
    @(posedge clk);
  endtask

  // Write all five registers plus one unmapped index, which must be ignored.
  // Spare bits above radius and use_cube carry random values.
  task automatic load_region(input region_cfg_t rg);
    put_reg(CFG_CENTRE_X, rg.centre_x);
    put_reg(CFG_CENTRE_Y, rg.centre_y);
    put_reg(CFG_CENTRE_Z, rg.centre_z);
    put_reg(CFG_RADIUS,   {1'($urandom), rg.radius});
    put_reg(CFG_USE_CUBE, {(CFG_DATA_W - 1)'($urandom), rg.use_cube});
    put_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, 2 ** CFG_IDX_W - 1)),
            CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    region_loads++;
  endtask

  // One query: edges drawn from a small vertex pool so lookups hit often,
  // closed by last_edge. A table fill uses fresh vertices with one end on
  // the centre so every edge is selected and the table overflows.
  task automatic run_query(input int n_links, input int pool_size,
                           input bit fill_table, input bit noisy);
    logic [INDEX_WIDTH-1:0] pool [$];
    in_item_t s;
    coord3_t  a, b;
    for (int i = 0; i < pool_size; i++) pool.push_back(INDEX_WIDTH'($urandom));
    for (int k = 0; k < n_links; k++) begin
      if (fill_table) begin
        a = pick_point(PT_CENTRE);
        b = pick_point(PT_ANY);
        s.first_vertex  = INDEX_WIDTH'($urandom);
        s.second_vertex = INDEX_WIDTH'($urandom);
      end else begin
        a = pick_point(noisy ? PT_ANY : draw_kind());
        b = pick_point(noisy ? PT_ANY : draw_kind());
        s.first_vertex  = pool[$urandom_range(0, pool.size() - 1)];
        s.second_vertex = ($urandom_range(0, 7) == 0) ? s.first_vertex
                                                       : pool[$urandom_range(0, pool.size() - 1)];
      end
      s.first_x   = a.x;
      s.first_y   = a.y;
      s.first_z   = a.z;
      s.second_x  = b.x;
      s.second_y  = b.y;
      s.second_z  = b.z;
      s.last_edge = (k == n_links - 1);
      send_edge(s, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
               $realtime, results_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (reindex_due.size() == 0) begin
        flag_mismatch("arrived with no edge outstanding", out_ch.data, 0);
      end else begin
        due_head = reindex_due.pop_front();
        if (out_ch.data.edge_selected !== due_head.edge_selected)
          flag_mismatch("edge_selected", out_ch.data.edge_selected, due_head.edge_selected);
        if (out_ch.data.new_first_index !== due_head.new_first_index)
          flag_mismatch("new_first_index", out_ch.data.new_first_index,
                        due_head.new_first_index);
        if (out_ch.data.new_second_index !== due_head.new_second_index)
          flag_mismatch("new_second_index", out_ch.data.new_second_index,
                        due_head.new_second_index);
        if (out_ch.data.table_overflow !== due_head.table_overflow)
          flag_mismatch("table_overflow", out_ch.data.table_overflow,
                        due_head.table_overflow);
        if (out_ch.data.selected_edges !== due_head.selected_edges)
          flag_mismatch("selected_edges", out_ch.data.selected_edges,
                        due_head.selected_edges);
        if (out_ch.data.distinct_vertices !== due_head.distinct_vertices)
          flag_mismatch("distinct_vertices", out_ch.data.distinct_vertices,
                        due_head.distinct_vertices);
      end
    end
  end

  // Watchdog: any transfer or register write resets the quiet count.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, reindex_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: draw a stall per result, or serve the long hold-off when
  // one is requested; keep ready high across back-to-back results.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end
      stall = steady_out ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    region_cfg_t base_region;
    int          phase;
    int          n_queries;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_off_len = 0;
    steady_in    = 1'b0;
    steady_out   = 1'b0;
    base_region  = '0;
    region_cx    = '0;
    region_cy    = '0;
    region_cz    = '0;
    region_rad   = '0;
    region_cube  = 1'b0;
    slots_used   = 0;
    query_edges  = 0;

    // Directed rows. The first six run on the reset region (a point sphere
    // at the origin) and carry their result by hand.
    // Both ends at opposite corners: nothing selected.
    probe_rows.push_back('{1'b0, base_region,
      mk_link(0, CMIN, CMIN, CMIN, 20'hFFFFF, CMAX, CMAX, CMAX, 1'b0),
      1'b1, mk_result(1'b0, 0, 0, 1'b0, 0, 0)});
    // Only the first end on the centre: both ends still get slots.
    probe_rows.push_back('{1'b0, base_region,
      mk_link(0, 0, 0, 0, 20'hFFFFF, CMAX, CMAX, CMAX, 1'b0),
      1'b1, mk_result(1'b1, 0, 1, 1'b0, 1, 2)});
    // Same vertex at both ends: second lookup hits the first one's slot.
    probe_rows.push_back('{1'b0, base_region,
      mk_link(5, 1, 0, 0, 5, 0, 0, 0, 1'b0),
      1'b1, mk_result(1'b1, 2, 2, 1'b0, 2, 3)});
    // Both vertices already known.
    probe_rows.push_back('{1'b0, base_region,
      mk_link(20'hFFFFF, 0, 0, 0, 0, 0, 0, -1, 1'b0),
      1'b1, mk_result(1'b1, 1, 0, 1'b0, 3, 3)});
    // Unselected last edge reports the totals, then the query clears.
    probe_rows.push_back('{1'b0, base_region,
      mk_link(20'h5A5A5, 0, 0, 1, 20'hA5A5A, 0, -1, 0, 1'b1),
      1'b1, mk_result(1'b0, 0, 0, 1'b0, 3, 3)});
    probe_rows.push_back('{1'b0, base_region,
      mk_link(7, 0, 0, 0, 8, 0, 0, 0, 1'b1),
      1'b1, mk_result(1'b1, 0, 1, 1'b0, 1, 2)});
    // Unit cube: corner in, one past the face out.
    probe_rows.push_back('{1'b1, mk_region(0, 0, 0, 256, 1'b1),
      mk_link(10, 256, -256, 256, 11, CMAX, 0, 0, 1'b0), 1'b0, '0});
    probe_rows.push_back('{1'b0, base_region,
      mk_link(12, 257, 0, 0, 13, 0, 0, -257, 1'b0), 1'b0, '0});
    probe_rows.push_back('{1'b0, base_region,
      mk_link(14, CMIN, CMIN, CMIN, 14, 256, 256, 256, 1'b0), 1'b0, '0});
    // Unit sphere: on the surface, just inside and just outside the rim.
    probe_rows.push_back('{1'b1, mk_region(0, 0, 0, 256, 1'b0),
      mk_link(10, 256, 0, 0, 15, 256, 256, 256, 1'b0), 1'b0, '0});
    probe_rows.push_back('{1'b0, base_region,
      mk_link(16, 181, 181, 0, 17, 182, 181, 0, 1'b0), 1'b0, '0});
    probe_rows.push_back('{1'b0, base_region,
      mk_link(18, 182, 181, 0, 19, 0, -257, 0, 1'b1), 1'b0, '0});
    // Largest sphere on a corner centre: full-span differences, exact radius.
    probe_rows.push_back('{1'b1, mk_region(CMAX, CMIN, CMAX, RMAX, 1'b0),
      mk_link(20, CMIN, CMAX, CMIN, 21, 0, CMIN, CMAX, 1'b0), 1'b0, '0});
    probe_rows.push_back('{1'b0, base_region,
      mk_link(22, CMAX, CMIN, CMAX, 23, CMIN, CMIN, CMIN, 1'b0), 1'b0, '0});
    // Largest cube at the low corner.
    probe_rows.push_back('{1'b1, mk_region(CMIN, CMIN, CMIN, RMAX, 1'b1),
      mk_link(24, CMAX, -1, -1, 25, -1, -1, -1, 1'b0), 1'b0, '0});
    // Zero-size cube: only the centre itself.
    probe_rows.push_back('{1'b1, mk_region(0, 0, 0, 0, 1'b1),
      mk_link(26, 0, 0, 0, 27, 1, 0, 0, 1'b1), 1'b0, '0});

    // Hold reset, release it at a clock edge.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i]) begin
      if (probe_rows[i].reconf) begin
        settle();
        load_region(probe_rows[i].region);
      end
      send_edge(probe_rows[i].stim, probe_rows[i].typed, probe_rows[i].want);
    end

    // Random phases: new region each phase, idle style drawn per side.
    phase = 0;
    while (sent_links < ITEM_TARGET) begin
      settle();
      load_region(pick_region(phase));
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      // Stall the receiver for a long stretch while edges keep coming.
      if (phase == PRESSURE_PHASE) begin
        steady_in    = 1'b1;
        hold_off_len = HOLD_OFF;
      end
      n_queries = $urandom_range(4, 8);
      for (int q = 0; q < n_queries; q++) begin
        // Pause the sender once until the block has drained completely.
        if (phase == PAUSE_PHASE && q == 2) settle();
        run_query($urandom_range(1, 24), $urandom_range(1, 40), 1'b0,
                  $urandom_range(0, 5) == 0);
      end
      if (phase == 3 || phase == 6) run_query(FILL_LINKS, 0, 1'b1, 1'b0);
      phase++;
    end

    // Drain, then leave room for anything the block should not send.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d edges under %0d region settings: %0d selected, %0d hit a full table.",
             sent_links, region_loads, selected_links, full_hits);
    $display("%0d results checked, %0d field mismatches.", results_checked, mismatches);
    if (mismatches == 0 && reindex_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/resr_pkg.sv
rtl/resr_if.sv
rtl/resr_datapath.sv
rtl/resr_ctrl.sv
rtl/region_edge_select_reindex.sv
rtl/resr_checker.sv
dv/region_edge_select_reindex_tb.sv
